// ----- rtl/core/rsfc_pkg.sv -----
// shared constants for the ray sphere far clip core
package rsfc_pkg;

  localparam int NUM_AXES = 3;
  localparam int SQRT_RADIX_BITS = 2;

  typedef logic hit_t;

endpackage

// ----- rtl/core/rsfc_if.sv -----
// request and result channel interfaces for the ray sphere far clip core
interface rsfc_in_if #(
  parameter int COORD_BITS = 24,
  parameter int DIR_FRAC_BITS = 14
) ();
  logic                              valid;
  logic                              ready;
  logic signed [COORD_BITS-1:0]      origin_x;
  logic signed [COORD_BITS-1:0]      origin_y;
  logic signed [COORD_BITS-1:0]      origin_z;
  logic signed [DIR_FRAC_BITS+1:0]   dir_x;
  logic signed [DIR_FRAC_BITS+1:0]   dir_y;
  logic signed [DIR_FRAC_BITS+1:0]   dir_z;
  logic signed [COORD_BITS-1:0]      centre_x;
  logic signed [COORD_BITS-1:0]      centre_y;
  logic signed [COORD_BITS-1:0]      centre_z;
  logic        [COORD_BITS-2:0]      radius;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  centre_x, centre_y, centre_z, radius, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                centre_x, centre_y, centre_z, radius, output ready);
endinterface

interface rsfc_out_if #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  rsfc_pkg::hit_t               hit;

  modport source (output valid, point_x, point_y, point_z, hit, input ready);
  modport sink (input valid, point_x, point_y, point_z, hit, output ready);
endinterface

// ----- rtl/core/rsfc_isqrt.sv -----
// pipelined integer square root, one root bit per stage, with a carried payload
module rsfc_isqrt #(
  parameter int W   = 60,
  parameter int PLW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [W-1:0]       in_rad,
  input  logic [PLW-1:0]     in_pl,
  output logic               out_valid,
  output logic [W/2-1:0]     out_root,
  output logic [PLW-1:0]     out_pl
);

  localparam int Q = W / rsfc_pkg::SQRT_RADIX_BITS;

  logic           v_r    [Q];
  logic [Q+1:0]   rem_r  [Q];
  logic [Q-1:0]   root_r [Q];
  logic [W-1:0]   rad_r  [Q];
  logic [PLW-1:0] pl_r   [Q];

  genvar k;
  generate
    for (k = 0; k < Q; k++) begin : g_stage
      logic           v_in;
      logic [Q+1:0]   rem_in;
      logic [Q-1:0]   root_in;
      logic [W-1:0]   rad_in;
      logic [PLW-1:0] pl_in;
      logic [Q+1:0]   cur;
      logic [Q+1:0]   trial;
      logic           ge;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = in_rad;
        assign pl_in   = in_pl;
      end else begin : g_next
        assign v_in    = v_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
        assign rad_in  = rad_r[k-1];
        assign pl_in   = pl_r[k-1];
      end

      assign cur   = {rem_in[Q-1:0], rad_in[W-1:W-2]};
      assign trial = {root_in, 2'b01};
      assign ge    = (cur >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k]  <= ge ? (cur - trial) : cur;
          root_r[k] <= {root_in[Q-2:0], ge};
          rad_r[k]  <= {rad_in[W-3:0], 2'b00};
          pl_r[k]   <= pl_in;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[Q-1];
  assign out_root  = root_r[Q-1];
  assign out_pl    = pl_r[Q-1];

endmodule

// ----- rtl/core/ray_sphere_far_clip_core.sv -----
// ray sphere far clip core: far intersection of a ray with a sphere, fixed point
//
// in_ch carries one request: ray origin, direction (DIR_FRAC_BITS fraction bits),
// sphere centre and radius. out_ch returns the far intersection point and a hit
// flag; on a miss the point is zero. one result per request, in request order.
// the pipeline has six front stages for the dot product, squares and radius test,
// one stage per root bit in the square root pipeline (COORD_BITS + 6 stages),
// then the scale stage and the output register. a request can enter every cycle
// while out_ch is not stalled.
// all stages advance together; when out_ch is stalled with a result waiting the
// whole pipeline holds and in_ch.ready drops, so nothing is lost or repeated.
// bubbles in the pipeline are not squeezed out while the output is stalled.
// reset clears every valid bit; the datapath needs none.
// no configuration registers.
module ray_sphere_far_clip_core #(
  parameter int COORD_BITS    = 24,
  parameter int DIR_FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  rsfc_in_if.sink    in_ch,
  rsfc_out_if.source out_ch
);

  localparam int NA  = rsfc_pkg::NUM_AXES;
  localparam int CB  = COORD_BITS;
  localparam int DFB = DIR_FRAC_BITS;
  localparam int DB  = DFB + 2;
  localparam int RW  = CB - 1;
  localparam int DW  = CB + 1;
  localparam int PRW = DW + DB;
  localparam int PW  = PRW + 2;
  localparam int PBW = PW - DFB;
  localparam int DQW = 2 * DW;
  localparam int DDW = DQW + 2;
  localparam int SQW = 2 * PBW + 2;
  localparam int Q   = SQW / rsfc_pkg::SQRT_RADIX_BITS;
  localparam int TW  = Q + 1;
  localparam int MW  = TW + DB + 1;
  localparam int XW  = MW - DFB + 2;
  localparam int PLW = NA * CB + NA * DB + PBW + 1;

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: differences
  logic                 v1_r;
  logic signed [CB-1:0] o1_r [NA];
  logic signed [DB-1:0] u1_r [NA];
  logic signed [DW-1:0] d1_r [NA];
  logic [RW-1:0]        r1_r;
  logic signed [CB-1:0] in_o [NA];
  logic signed [CB-1:0] in_c [NA];
  logic signed [DB-1:0] in_u [NA];

  assign in_o[0] = in_ch.origin_x;
  assign in_o[1] = in_ch.origin_y;
  assign in_o[2] = in_ch.origin_z;
  assign in_c[0] = in_ch.centre_x;
  assign in_c[1] = in_ch.centre_y;
  assign in_c[2] = in_ch.centre_z;
  assign in_u[0] = in_ch.dir_x;
  assign in_u[1] = in_ch.dir_y;
  assign in_u[2] = in_ch.dir_z;

  // stage 2: products
  logic                  v2_r;
  logic signed [CB-1:0]  o2_r [NA];
  logic signed [DB-1:0]  u2_r [NA];
  logic signed [PRW-1:0] du2_r [NA];
  logic [DQW-1:0]        dsq2_r [NA];
  logic [RW-1:0]         r2_r;

  // stage 3: sums
  logic                 v3_r;
  logic signed [CB-1:0] o3_r [NA];
  logic signed [DB-1:0] u3_r [NA];
  logic signed [PW-1:0] dot3_r;
  logic [DDW-1:0]       dd3_r;
  logic [2*RW-1:0]      rsq3_r;

  // stage 4: projection
  logic                 v4_r;
  logic signed [CB-1:0] o4_r [NA];
  logic signed [DB-1:0] u4_r [NA];
  logic                 neg4_r;
  logic [PBW-1:0]       p4_r;
  logic [DDW-1:0]       dd4_r;
  logic [2*RW-1:0]      rsq4_r;

  // stage 5: projection squared
  logic                 v5_r;
  logic signed [CB-1:0] o5_r [NA];
  logic signed [DB-1:0] u5_r [NA];
  logic                 neg5_r;
  logic [PBW-1:0]       p5_r;
  logic [2*PBW-1:0]     pp5_r;
  logic [DDW-1:0]       dd5_r;
  logic [2*RW-1:0]      rsq5_r;

  // stage 6: radius test
  logic                 v6_r;
  logic [SQW-1:0]       diff6_r;
  logic [PLW-1:0]       pl6_r;
  logic [SQW-1:0]       rr6;
  logic                 hit6;

  always_comb begin
    rr6  = SQW'(rsq5_r) + SQW'(pp5_r);
    hit6 = !neg5_r && (SQW'(dd5_r) <= rr6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        o1_r[i]   <= in_o[i];
        u1_r[i]   <= in_u[i];
        d1_r[i]   <= DW'(in_c[i]) - DW'(in_o[i]);
        o2_r[i]   <= o1_r[i];
        u2_r[i]   <= u1_r[i];
        du2_r[i]  <= PRW'(d1_r[i]) * PRW'(u1_r[i]);
        dsq2_r[i] <= DQW'(d1_r[i]) * DQW'(d1_r[i]);
        o3_r[i]   <= o2_r[i];
        u3_r[i]   <= u2_r[i];
        o4_r[i]   <= o3_r[i];
        u4_r[i]   <= u3_r[i];
        o5_r[i]   <= o4_r[i];
        u5_r[i]   <= u4_r[i];
      end
      r1_r    <= in_ch.radius;
      r2_r    <= r1_r;
      dot3_r  <= PW'(du2_r[0]) + PW'(du2_r[1]) + PW'(du2_r[2]);
      dd3_r   <= DDW'(dsq2_r[0]) + DDW'(dsq2_r[1]) + DDW'(dsq2_r[2]);
      rsq3_r  <= (2*RW)'(r2_r) * (2*RW)'(r2_r);
      neg4_r  <= dot3_r[PW-1];
      p4_r    <= dot3_r[PW-1:DFB];
      dd4_r   <= dd3_r;
      rsq4_r  <= rsq3_r;
      neg5_r  <= neg4_r;
      p5_r    <= p4_r;
      pp5_r   <= (2*PBW)'(p4_r) * (2*PBW)'(p4_r);
      dd5_r   <= dd4_r;
      rsq5_r  <= rsq4_r;
      diff6_r <= rr6 - SQW'(dd5_r);
      pl6_r   <= {o5_r[0], o5_r[1], o5_r[2], u5_r[0], u5_r[1], u5_r[2], p5_r, hit6};
    end
  end

  // square root pipeline
  logic           vs_w;
  logic [Q-1:0]   root_w;
  logic [PLW-1:0] pls_w;

  rsfc_isqrt #(
    .W   (SQW),
    .PLW (PLW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_rad    (diff6_r),
    .in_pl     (pl6_r),
    .out_valid (vs_w),
    .out_root  (root_w),
    .out_pl    (pls_w)
  );

  logic signed [CB-1:0] os [NA];
  logic signed [DB-1:0] us [NA];
  logic [PBW-1:0]       ps;
  logic                 hs;
  logic [TW-1:0]        t_s;

  always_comb begin
    {os[0], os[1], os[2], us[0], us[1], us[2], ps, hs} = pls_w;
    t_s = TW'(ps) + TW'(root_w);
  end

  // stage 7: scale by direction
  logic                 v7_r;
  logic signed [CB-1:0] o7_r [NA];
  logic                 un7_r [NA];
  logic [MW-1:0]        m7_r [NA];
  logic                 h7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= vs_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        o7_r[i]  <= os[i];
        un7_r[i] <= us[i][DB-1];
        m7_r[i]  <= MW'(t_s) *
                    MW'($unsigned(us[i][DB-1] ? DB'(-us[i]) : DB'(us[i])));
      end
      h7_r <= hs;
    end
  end

  // stage 8: offset, saturate, output register
  logic signed [XW-1:0] step_s [NA];
  logic signed [XW-1:0] sum_s  [NA];
  logic signed [CB-1:0] pt_s   [NA];
  logic signed [CB-1:0] pt_r   [NA];
  logic                 hit_r;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (un7_r[i]) begin
        step_s[i] = -$signed(XW'((m7_r[i] + MW'((1 << DFB) - 1)) >> DFB));
      end else begin
        step_s[i] = $signed(XW'(m7_r[i] >> DFB));
      end
      sum_s[i] = XW'(o7_r[i]) + step_s[i];
      if (sum_s[i][XW-1:CB-1] != {(XW-CB+1){sum_s[i][XW-1]}}) begin
        pt_s[i] = sum_s[i][XW-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
      end else begin
        pt_s[i] = sum_s[i][CB-1:0];
      end
      if (!h7_r) begin
        pt_s[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        pt_r[i] <= pt_s[i];
      end
      hit_r <= h7_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.point_x = pt_r[0];
  assign out_ch.point_y = pt_r[1];
  assign out_ch.point_z = pt_r[2];
  assign out_ch.hit     = hit_r;

endmodule

// ----- rtl/core/rsfc_checker.sv -----
// port-level checker for the ray sphere far clip core, bound to the top level
module rsfc_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] point_x,
  input logic [COORD_BITS-1:0] point_y,
  input logic [COORD_BITS-1:0] point_z,
  input logic                  hit
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({point_x, point_y, point_z, hit}))
    else $error("result changed while stalled");

  // miss gives a zero point
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> point_x == '0 && point_y == '0 && point_z == '0)
    else $error("miss with nonzero point");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty output slot always takes a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request refused with empty output");

endmodule

bind ray_sphere_far_clip_core rsfc_checker #(
  .COORD_BITS (COORD_BITS)
) u_rsfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y),
  .point_z   (out_ch.point_z),
  .hit       (out_ch.hit)
);
